/* src/pts_pkg.sv */
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and constants of the periodic task tick scheduler: command
// codes, item layouts, slot memory entry and controller states.
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int unsigned TASK_SLOTS_DEF = 8;

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_CREATE  = 3'd1,
    CMD_SUSPEND = 3'd2,
    CMD_RESUME  = 3'd3,
    CMD_DELETE  = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [2:0]  task_id;
    logic [15:0] period;
    logic [15:0] first_delay;
  } pts_in_t;

  typedef struct packed {
    logic       fired;
    logic [2:0] fired_id;
    logic       last;
  } pts_out_t;

  typedef struct packed {
    logic [15:0] period;
    logic [15:0] countdown;
  } slot_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } state_e;

endpackage

/* src/periodic_task_tick_scheduler_core.sv */
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler_core
// Table of periodic task slots with create, suspend, resume, delete and tick
// commands; a tick reports every slot that fires, in ascending slot order.
// ----------------------------------------------------------------------------
// Period and countdown of each slot live in one synchronous memory with a
// registered read; valid and ready marks are flip-flops cleared at reset. A
// tick walks the memory one slot per cycle, reading the next slot while the
// current one is updated and written back; the walk pauses while a report
// waits on a stalled output. Create, suspend, resume, delete and unknown
// commands give one empty item. The output register lets a new command in
// while the last result still waits.
module periodic_task_tick_scheduler_core #(
  parameter int unsigned TASK_SLOTS = pts_pkg::TASK_SLOTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pts_pkg::pts_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pts_pkg::pts_out_t out_data_o
);

  localparam int unsigned SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int unsigned CNT_W  = $clog2(TASK_SLOTS + 1);
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(TASK_SLOTS);

  pts_pkg::state_e      state_q, state_d;
  logic [CNT_W-1:0]     rd_cnt_q, rd_cnt_d;
  logic                 ex_vld_q, ex_vld_d;
  logic [SLOT_W-1:0]    ex_idx_q, ex_idx_d;
  logic                 pend_vld_q, pend_vld_d;
  logic [SLOT_W-1:0]    pend_idx_q, pend_idx_d;
  logic                 out_vld_q, out_vld_d;
  pts_pkg::pts_out_t    out_data_q, out_data_d;
  logic [TASK_SLOTS-1:0] valid_q, valid_d;
  logic [TASK_SLOTS-1:0] ready_q, ready_d;

  pts_pkg::slot_entry_t slot_mem [TASK_SLOTS];
  pts_pkg::slot_entry_t rdata_q;
  pts_pkg::slot_entry_t mem_wdata;
  logic [SLOT_W-1:0]    mem_waddr;
  logic                 mem_we;
  logic                 mem_re;

  logic              in_acc;
  logic              id_ok;
  logic [SLOT_W-1:0] id_idx;
  logic              out_free;
  logic              out_load;
  logic              ex_active;
  logic              ex_fire;
  logic              hold;

  assign in_stall_o  = (state_q != pts_pkg::ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign id_ok       = (32'(in_data_i.task_id) < TASK_SLOTS);
  assign id_idx      = SLOT_W'(in_data_i.task_id);
  assign out_free    = !out_vld_q || !out_stall_i;
  assign ex_active   = valid_q[ex_idx_q] && ready_q[ex_idx_q];
  assign ex_fire     = ex_vld_q && ex_active && (rdata_q.countdown == '0);
  assign hold        = ex_fire && pend_vld_q && !out_free;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    state_d    = state_q;
    rd_cnt_d   = rd_cnt_q;
    ex_vld_d   = ex_vld_q;
    ex_idx_d   = ex_idx_q;
    pend_vld_d = pend_vld_q;
    pend_idx_d = pend_idx_q;
    valid_d    = valid_q;
    ready_d    = ready_q;
    out_load   = 1'b0;
    out_data_d = out_data_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = ex_idx_q;
    mem_wdata  = rdata_q;
    unique case (state_q)
      pts_pkg::ST_IDLE: begin
        if (in_acc) begin
          pend_vld_d = 1'b0;
          if (in_data_i.command == pts_pkg::CMD_TICK) begin
            rd_cnt_d = '0;
            ex_vld_d = 1'b0;
            state_d  = pts_pkg::ST_WALK;
          end else begin
            state_d = pts_pkg::ST_FINISH;
            if (id_ok) begin
              unique case (in_data_i.command)
                pts_pkg::CMD_CREATE: begin
                  mem_we              = 1'b1;
                  mem_waddr           = id_idx;
                  mem_wdata.period    = in_data_i.period;
                  mem_wdata.countdown = in_data_i.first_delay;
                  valid_d[id_idx]     = 1'b1;
                  ready_d[id_idx]     = 1'b1;
                end
                pts_pkg::CMD_SUSPEND: ready_d[id_idx] = 1'b0;
                pts_pkg::CMD_RESUME:  ready_d[id_idx] = 1'b1;
                pts_pkg::CMD_DELETE:  valid_d[id_idx] = 1'b0;
                default: ;
              endcase
            end
          end
        end
      end
      pts_pkg::ST_WALK: begin
        if (!hold) begin
          if (rd_cnt_q != CNT_END) begin
            mem_re   = 1'b1;
            ex_vld_d = 1'b1;
            ex_idx_d = rd_cnt_q[SLOT_W-1:0];
            rd_cnt_d = rd_cnt_q + 1'b1;
          end else begin
            ex_vld_d = 1'b0;
          end
          if (ex_vld_q && ex_active) begin
            mem_we              = 1'b1;
            mem_waddr           = ex_idx_q;
            mem_wdata.period    = rdata_q.period;
            mem_wdata.countdown = ex_fire ? (rdata_q.period - 16'd1)
                                          : (rdata_q.countdown - 16'd1);
          end
          if (ex_fire) begin
            pend_vld_d = 1'b1;
            pend_idx_d = ex_idx_q;
            if (pend_vld_q) begin
              out_load            = 1'b1;
              out_data_d.fired    = 1'b1;
              out_data_d.fired_id = 3'(pend_idx_q);
              out_data_d.last     = 1'b0;
            end
          end
          if (ex_vld_q && (rd_cnt_q == CNT_END)) begin
            state_d = pts_pkg::ST_FINISH;
          end
        end
      end
      pts_pkg::ST_FINISH: begin
        if (out_free) begin
          out_load            = 1'b1;
          out_data_d.fired    = pend_vld_q;
          out_data_d.fired_id = pend_vld_q ? 3'(pend_idx_q) : 3'd0;
          out_data_d.last     = 1'b1;
          state_d             = pts_pkg::ST_IDLE;
        end
      end
      default: state_d = pts_pkg::ST_IDLE;
    endcase
    out_vld_d = out_load || (out_vld_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= pts_pkg::ST_IDLE;
      rd_cnt_q   <= '0;
      ex_vld_q   <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      valid_q    <= '0;
      ready_q    <= '0;
    end else begin
      state_q    <= state_d;
      rd_cnt_q   <= rd_cnt_d;
      ex_vld_q   <= ex_vld_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
      valid_q    <= valid_d;
      ready_q    <= ready_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ex_idx_q   <= ex_idx_d;
    pend_idx_q <= pend_idx_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= slot_mem[rd_cnt_q[SLOT_W-1:0]];
    end
  end

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_stall_i) |-> !out_load)
    else $error("output item overwritten while stalled");

  a_hold_keeps_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pts_pkg::ST_WALK && hold) |=> ($stable(ex_idx_q) && $stable(rdata_q)))
    else $error("slot in update lost during hold");

  a_finish_after_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pts_pkg::ST_WALK && state_d == pts_pkg::ST_FINISH)
      |=> (!ex_vld_q && rd_cnt_q == CNT_END))
    else $error("walk ended before all slots were updated");

  a_no_rw_same_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (mem_waddr != rd_cnt_q[SLOT_W-1:0]))
    else $error("read and write of the same slot in one cycle");
`endif

endmodule

/* tb/periodic_task_tick_scheduler_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler_core_tb
// Drives commands into the task scheduler and checks each reported item
// against an in-bench slot table model. A directed table covers reset
// behavior, unknown commands, commands on empty slots, period and delay
// extremes, suspend/resume/delete and a tick where every slot fires. A
// random run follows, under three idle/stall mixes on the two channels.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler_core_tb;

  localparam int SLOTS = pts_pkg::TASK_SLOTS_DEF;
  localparam int RANDOM_ITEMS = 105;
  localparam int PLAN_ITEMS = 25;
  localparam int TOTAL_ITEMS = PLAN_ITEMS + RANDOM_ITEMS;
  localparam logic [2:0] CMD_RSVD5 = 3'd5;
  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;
  localparam pts_pkg::pts_out_t NO_FIRE = '{fired: 1'b0, fired_id: 3'd0, last: 1'b1};

  typedef struct {
    pts_pkg::pts_in_t  item;
    bit                typed;
    pts_pkg::pts_out_t typed_res;
  } plan_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  pts_pkg::pts_in_t  in_item = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  pts_pkg::pts_out_t out_item;

  int unsigned sender_idle = 23;
  int unsigned stall_pct = 70;

  logic        slot_live [SLOTS];
  logic        slot_run  [SLOTS];
  logic [15:0] slot_per  [SLOTS];
  logic [15:0] slot_count[SLOTS];

  pts_pkg::pts_out_t step_fires[$];
  pts_pkg::pts_out_t due_fires[$];
  plan_row_t         plan[$];

  int errors = 0;
  int items_sent = 0;
  int ticks_sent = 0;
  int results_seen = 0;
  int firings_seen = 0;

  periodic_task_tick_scheduler_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_item)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic advance_schedule(input pts_pkg::pts_in_t it);
    pts_pkg::pts_out_t f;
    step_fires.delete();
    if (it.command == pts_pkg::CMD_TICK) begin
      for (int s = 0; s < SLOTS; s++) begin
        if (slot_live[s] && slot_run[s]) begin
          if (slot_count[s] == 16'd0) begin
            slot_count[s] = slot_per[s] - 16'd1;
            step_fires.push_back('{fired: 1'b1, fired_id: 3'(s), last: 1'b0});
          end else begin
            slot_count[s] = slot_count[s] - 16'd1;
          end
        end
      end
      if (step_fires.size() == 0) begin
        step_fires.push_back(NO_FIRE);
      end else begin
        f = step_fires.pop_back();
        f.last = 1'b1;
        step_fires.push_back(f);
      end
    end else begin
      case (it.command)
        pts_pkg::CMD_CREATE: begin
          slot_per[it.task_id] = it.period;
          slot_count[it.task_id] = it.first_delay;
          slot_run[it.task_id] = 1'b1;
          slot_live[it.task_id] = 1'b1;
        end
        pts_pkg::CMD_SUSPEND: slot_run[it.task_id] = 1'b0;
        pts_pkg::CMD_RESUME:  slot_run[it.task_id] = 1'b1;
        pts_pkg::CMD_DELETE:  slot_live[it.task_id] = 1'b0;
        default: ;
      endcase
      step_fires.push_back(NO_FIRE);
    end
  endtask

  task automatic add_row(input logic [2:0] cmd, input logic [2:0] id, input logic [15:0] per,
                         input logic [15:0] dly, input bit typed,
                         input pts_pkg::pts_out_t res);
    plan_row_t r;
    r.item = '{command: cmd, task_id: id, period: per, first_delay: dly};
    r.typed = typed;
    r.typed_res = res;
    plan.push_back(r);
  endtask

  // Hold the item until accepted, then queue what it should report.
  task automatic offer_item(input pts_pkg::pts_in_t it, input bit typed,
                            input pts_pkg::pts_out_t typed_res);
    while ($urandom_range(99) < sender_idle) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk_i); while (in_stall);
    advance_schedule(it);
    if (typed) begin
      due_fires.push_back(typed_res);
    end else begin
      foreach (step_fires[k]) due_fires.push_back(step_fires[k]);
    end
    items_sent++;
    if (it.command == pts_pkg::CMD_TICK) ticks_sent++;
    @(negedge clk_i);
  endtask

  function automatic pts_pkg::pts_in_t random_item();
    pts_pkg::pts_in_t it;
    int unsigned r;
    r = $urandom_range(99);
    it.task_id = 3'($urandom_range(SLOTS - 1));
    it.period = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(5));
    it.first_delay = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(4));
    if (r < 50)      it.command = pts_pkg::CMD_TICK;
    else if (r < 72) it.command = pts_pkg::CMD_CREATE;
    else if (r < 82) it.command = pts_pkg::CMD_SUSPEND;
    else if (r < 92) it.command = pts_pkg::CMD_RESUME;
    else if (r < 97) it.command = pts_pkg::CMD_DELETE;
    else             it.command = CMD_RSVD5 + 3'($urandom_range(2));
    return it;
  endfunction

  always @(posedge clk_i) begin
    pts_pkg::pts_out_t want;
    if (rst_ni && out_valid && !out_stall) begin
      results_seen++;
      if (out_item.fired) firings_seen++;
      if (due_fires.size() == 0) begin
        errors++;
        $display("%0t: unexpected item fired=%0b id=%0d last=%0b", $time,
                 out_item.fired, out_item.fired_id, out_item.last);
      end else begin
        want = due_fires.pop_front();
        if (out_item.fired !== want.fired || out_item.fired_id !== want.fired_id ||
            out_item.last !== want.last) begin
          errors++;
          $display("%0t: expected fired=%0b id=%0d last=%0b, got fired=%0b id=%0d last=%0b",
                   $time, want.fired, want.fired_id, want.last,
                   out_item.fired, out_item.fired_id, out_item.last);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("periodic_task_tick_scheduler_core_tb NOT OK");
    $finish;
  end

  initial begin
    pts_pkg::pts_in_t it;
    int idx;
    int random_done;
    for (int s = 0; s < SLOTS; s++) begin
      slot_live[s] = 1'b0;
      slot_run[s] = 1'b0;
      slot_per[s] = '0;
      slot_count[s] = '0;
    end

    // reset state, unknown commands, commands on empty slots
    add_row(pts_pkg::CMD_TICK,    3'd0, 16'h0000, 16'h0000, 1'b1, NO_FIRE);
    add_row(CMD_RSVD5,            3'd7, 16'hFFFF, 16'hFFFF, 1'b1, NO_FIRE);
    add_row(CMD_RSVD6,            3'd3, 16'h5A5A, 16'hA5A5, 1'b1, NO_FIRE);
    add_row(CMD_RSVD7,            3'd0, 16'h0000, 16'h0000, 1'b1, NO_FIRE);
    add_row(pts_pkg::CMD_RESUME,  3'd2, 16'h0000, 16'h0000, 1'b1, NO_FIRE);
    add_row(pts_pkg::CMD_TICK,    3'd0, 16'h0000, 16'h0000, 1'b1, NO_FIRE);
    // period and delay extremes, zero period wraps
    add_row(pts_pkg::CMD_CREATE,  3'd0, 16'h0000, 16'h0000, 1'b1, NO_FIRE);
    add_row(pts_pkg::CMD_CREATE,  3'd7, 16'hFFFF, 16'hFFFF, 1'b1, NO_FIRE);
    add_row(pts_pkg::CMD_CREATE,  3'd2, 16'h0001, 16'h0000, 1'b1, NO_FIRE);
    add_row(pts_pkg::CMD_TICK,    3'd0, 16'h0000, 16'h0000, 1'b0, NO_FIRE);
    add_row(pts_pkg::CMD_TICK,    3'd0, 16'h0000, 16'h0000, 1'b0, NO_FIRE);
    // suspend holds the countdown, delete then create rewrites the slot
    add_row(pts_pkg::CMD_SUSPEND, 3'd2, 16'h0000, 16'h0000, 1'b1, NO_FIRE);
    add_row(pts_pkg::CMD_TICK,    3'd0, 16'h0000, 16'h0000, 1'b0, NO_FIRE);
    add_row(pts_pkg::CMD_RESUME,  3'd2, 16'h0000, 16'h0000, 1'b1, NO_FIRE);
    add_row(pts_pkg::CMD_DELETE,  3'd0, 16'h0000, 16'h0000, 1'b1, NO_FIRE);
    add_row(pts_pkg::CMD_TICK,    3'd0, 16'h0000, 16'h0000, 1'b0, NO_FIRE);
    add_row(pts_pkg::CMD_CREATE,  3'd0, 16'h0001, 16'h0000, 1'b1, NO_FIRE);
    // every slot fires on the same tick
    add_row(pts_pkg::CMD_CREATE,  3'd1, 16'h0001, 16'h0000, 1'b1, NO_FIRE);
    add_row(pts_pkg::CMD_CREATE,  3'd3, 16'h0001, 16'h0000, 1'b1, NO_FIRE);
    add_row(pts_pkg::CMD_CREATE,  3'd4, 16'h0001, 16'h0000, 1'b1, NO_FIRE);
    add_row(pts_pkg::CMD_CREATE,  3'd5, 16'h0001, 16'h0000, 1'b1, NO_FIRE);
    add_row(pts_pkg::CMD_CREATE,  3'd6, 16'h0001, 16'h0000, 1'b1, NO_FIRE);
    add_row(pts_pkg::CMD_CREATE,  3'd7, 16'h0001, 16'h0000, 1'b1, NO_FIRE);
    add_row(pts_pkg::CMD_TICK,    3'd0, 16'h0000, 16'h0000, 1'b0, NO_FIRE);
    add_row(pts_pkg::CMD_TICK,    3'd0, 16'h0000, 16'h0000, 1'b0, NO_FIRE);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    idx = 0;
    random_done = 0;
    while (idx < plan.size() || random_done < RANDOM_ITEMS) begin
      if (idx * 3 < TOTAL_ITEMS) begin
        sender_idle = 23;
        stall_pct = 70;
      end else if (idx * 3 < TOTAL_ITEMS * 2) begin
        sender_idle = 70;
        stall_pct = 23;
      end else begin
        sender_idle = 0;
        stall_pct = 0;
      end
      if (idx < plan.size()) begin
        offer_item(plan[idx].item, plan[idx].typed, plan[idx].typed_res);
      end else begin
        it = random_item();
        offer_item(it, 1'b0, NO_FIRE);
        if (it.command <= pts_pkg::CMD_DELETE) random_done++;
      end
      idx++;
    end
    in_valid <= 1'b0;

    while (due_fires.size() != 0) @(posedge clk_i);
    repeat (2 * SLOTS + 8) @(posedge clk_i);

    $display("Sent %0d commands (%0d ticks); checked %0d result items, %0d of them firings.",
             items_sent, ticks_sent, results_seen, firings_seen);
    if (errors == 0) begin
      $display("periodic_task_tick_scheduler_core_tb OK");
    end else begin
      $display("periodic_task_tick_scheduler_core_tb NOT OK");
    end
    $finish;
  end

endmodule
